// File: hw/rtl/hslrgb_pkg.sv
// Shared constants, types and the helper function of the HSL to RGB converter.
`timescale 1ns / 1ps

package hslrgb_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int HUE_W      = 12;
    localparam int SAT_W      = 13;
    localparam int LIT_W      = 13;
    localparam int CHAN_W     = 8;
    localparam int UNIT_W     = FRAC_BITS + 1;
    localparam int WIDE_W     = UNIT_W + 2;
    localparam int H6_W       = FRAC_BITS + 3;
    localparam int SEXT_W     = 3;
    localparam int NUM_STAGES = 6;

    localparam logic [UNIT_W-1:0] UNIT_ONE  = UNIT_W'(1) << FRAC_BITS;
    localparam logic [UNIT_W-1:0] UNIT_HALF = UNIT_W'(1) << (FRAC_BITS - 1);

    // Hue sextants, named by the colour range they span.
    localparam logic [SEXT_W-1:0] SEXT_RED_YELLOW    = 3'd0;
    localparam logic [SEXT_W-1:0] SEXT_YELLOW_GREEN  = 3'd1;
    localparam logic [SEXT_W-1:0] SEXT_GREEN_CYAN    = 3'd2;
    localparam logic [SEXT_W-1:0] SEXT_CYAN_BLUE     = 3'd3;
    localparam logic [SEXT_W-1:0] SEXT_BLUE_MAGENTA  = 3'd4;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    // Clamps a signed intermediate to the unit range [0, ONE].
    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [WIDE_W-1:0] x);
        logic [UNIT_W-1:0] res;
        if (x < 0)
        begin
            res = '0;
        end
        else if (x > $signed({2'b00, UNIT_ONE}))
        begin
            res = UNIT_ONE;
        end
        else
        begin
            res = x[UNIT_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/hslrgb_pipe_ctrl.sv
// Valid-bit chain and per-stage load enables of the converter pipeline.
`timescale 1ns / 1ps

module hslrgb_pipe_ctrl
    import hslrgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_valid,
    output logic       pix_stall,
    output logic       rgb_valid,
    input  logic       rgb_stall,
    output pipe_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;

    // A stage moves when it is empty or when the stage after it moves.
    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || !rgb_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = adv[0] ? pix_valid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign pix_stall = !adv[0];
    assign rgb_valid = vld_reg[NUM_STAGES-1];
    assign ctrl.load = adv;

endmodule

// File: hw/rtl/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB pixel converter: six-stage arithmetic pipeline.
`timescale 1ns / 1ps
// A pixel transfer accepted at the input passes through the stage registers 0 to 5 in order
// and is offered from the stage 5 output register.
// Throughput: one pixel per clock unless the output stalls; every stage holds a valid bit and
// empty stages fill up even while the output is stalled, so the pipeline runs back to back.
// The depth is set by the two multipliers (lightness times saturation, span times fraction),
// each followed by its own register. Reset clears only the valid bits; data is not reset.

module hsl_to_rgb_converter
    import hslrgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  logic [HUE_W-1:0]  hue,
    input  logic [SAT_W-1:0]  saturation,
    input  logic [LIT_W-1:0]  lightness,
    output logic              rgb_valid,
    input  logic              rgb_stall,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green,
    output logic [CHAN_W-1:0] blue
);

    pipe_ctrl_t ctrl;

    // The control block decides which stages take new data in each cycle. A stage loads
    // whenever it is empty or its successor is moving, so bubbles are squeezed out.
    hslrgb_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .ctrl      (ctrl)
    );

    // ------------------------------------------------------------------
    // Stage 0: saturate saturation and lightness to one, split the hue
    // (times six) into its sextant and the fraction within it.
    // ------------------------------------------------------------------
    logic [H6_W-1:0]   h6;
    logic [UNIT_W-1:0] sat_clamped;
    logic [UNIT_W-1:0] lit_clamped;

    logic [UNIT_W-1:0]    s0_reg;
    logic [UNIT_W-1:0]    l0_reg;
    logic [SEXT_W-1:0]    sext0_reg;
    logic [FRAC_BITS-1:0] frac0_reg;

    assign h6          = H6_W'(hue[FRAC_BITS-1:0]) * H6_W'(6);
    assign sat_clamped = (saturation > UNIT_ONE) ? UNIT_ONE : saturation[UNIT_W-1:0];
    assign lit_clamped = (lightness  > UNIT_ONE) ? UNIT_ONE : lightness[UNIT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s0_reg    <= sat_clamped;
            l0_reg    <= lit_clamped;
            sext0_reg <= h6[FRAC_BITS +: SEXT_W];
            frac0_reg <= h6[FRAC_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the single product lightness times saturation, truncated.
    // Both branches of v are built from it, since
    // (l * (ONE + s)) >> F equals l + ((l * s) >> F).
    // ------------------------------------------------------------------
    logic [2*UNIT_W-1:0] ls_prod;

    logic [UNIT_W-1:0]    ls1_reg;
    logic [UNIT_W-1:0]    s1_reg;
    logic [UNIT_W-1:0]    l1_reg;
    logic [SEXT_W-1:0]    sext1_reg;
    logic [FRAC_BITS-1:0] frac1_reg;

    assign ls_prod = (2*UNIT_W)'(l0_reg) * (2*UNIT_W)'(s0_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            ls1_reg   <= ls_prod[FRAC_BITS +: UNIT_W];
            s1_reg    <= s0_reg;
            l1_reg    <= l0_reg;
            sext1_reg <= sext0_reg;
            frac1_reg <= frac0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: v, m = 2l - v and the span v - m, each clamped to the unit
    // range. A v of zero marks the pixel as grey.
    // ------------------------------------------------------------------
    logic signed [WIDE_W-1:0] v_wide;
    logic [UNIT_W-1:0]        v_val;
    logic [UNIT_W-1:0]        m_val;
    logic signed [WIDE_W-1:0] span_wide;

    logic [UNIT_W-1:0]    v2_reg;
    logic [UNIT_W-1:0]    m2_reg;
    logic [UNIT_W-1:0]    span2_reg;
    logic [UNIT_W-1:0]    l2_reg;
    logic [SEXT_W-1:0]    sext2_reg;
    logic [FRAC_BITS-1:0] frac2_reg;
    logic                 gray2_reg;

    always_comb
    begin
        if (l1_reg <= UNIT_HALF)
        begin
            v_wide = $signed(WIDE_W'(l1_reg)) + $signed(WIDE_W'(ls1_reg));
        end
        else
        begin
            v_wide = $signed(WIDE_W'(l1_reg)) + $signed(WIDE_W'(s1_reg))
                   - $signed(WIDE_W'(ls1_reg));
        end
        v_val     = clamp_unit(v_wide);
        m_val     = clamp_unit($signed(WIDE_W'(l1_reg)) + $signed(WIDE_W'(l1_reg))
                               - $signed(WIDE_W'(v_val)));
        span_wide = $signed(WIDE_W'(v_val)) - $signed(WIDE_W'(m_val));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            v2_reg    <= v_val;
            m2_reg    <= m_val;
            span2_reg <= clamp_unit(span_wide);
            l2_reg    <= l1_reg;
            sext2_reg <= sext1_reg;
            frac2_reg <= frac1_reg;
            gray2_reg <= (v_val == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: vsf = (span * fraction) >> F, which stands in for a division.
    // ------------------------------------------------------------------
    localparam int VSF_PROD_W = UNIT_W + FRAC_BITS;

    logic [VSF_PROD_W-1:0] vsf_prod;

    logic [UNIT_W-1:0] vsf3_reg;
    logic [UNIT_W-1:0] v3_reg;
    logic [UNIT_W-1:0] m3_reg;
    logic [UNIT_W-1:0] l3_reg;
    logic [SEXT_W-1:0] sext3_reg;
    logic              gray3_reg;

    assign vsf_prod = VSF_PROD_W'(span2_reg) * VSF_PROD_W'(frac2_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            vsf3_reg  <= vsf_prod[FRAC_BITS +: UNIT_W];
            v3_reg    <= v2_reg;
            m3_reg    <= m2_reg;
            l3_reg    <= l2_reg;
            sext3_reg <= sext2_reg;
            gray3_reg <= gray2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: the rising and falling edges m + vsf and v - vsf, and
    // the per-sextant choice of v, m and those edges, or of l if grey.
    // ------------------------------------------------------------------
    logic [UNIT_W-1:0] mid_up;
    logic [UNIT_W-1:0] mid_down;
    logic [UNIT_W-1:0] r_sel;
    logic [UNIT_W-1:0] g_sel;
    logic [UNIT_W-1:0] b_sel;

    logic [UNIT_W-1:0] r4_reg;
    logic [UNIT_W-1:0] g4_reg;
    logic [UNIT_W-1:0] b4_reg;

    always_comb
    begin
        mid_up   = clamp_unit($signed(WIDE_W'(m3_reg)) + $signed(WIDE_W'(vsf3_reg)));
        mid_down = clamp_unit($signed(WIDE_W'(v3_reg)) - $signed(WIDE_W'(vsf3_reg)));
        if (gray3_reg)
        begin
            r_sel = l3_reg;
            g_sel = l3_reg;
            b_sel = l3_reg;
        end
        else
        begin
            unique case (sext3_reg)
                SEXT_RED_YELLOW:
                begin
                    r_sel = v3_reg;
                    g_sel = mid_up;
                    b_sel = m3_reg;
                end
                SEXT_YELLOW_GREEN:
                begin
                    r_sel = mid_down;
                    g_sel = v3_reg;
                    b_sel = m3_reg;
                end
                SEXT_GREEN_CYAN:
                begin
                    r_sel = m3_reg;
                    g_sel = v3_reg;
                    b_sel = mid_up;
                end
                SEXT_CYAN_BLUE:
                begin
                    r_sel = m3_reg;
                    g_sel = mid_down;
                    b_sel = v3_reg;
                end
                SEXT_BLUE_MAGENTA:
                begin
                    r_sel = mid_up;
                    g_sel = m3_reg;
                    b_sel = v3_reg;
                end
                // The magenta to red sextant; the hue never reaches the unused codes.
                default:
                begin
                    r_sel = v3_reg;
                    g_sel = m3_reg;
                    b_sel = mid_down;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            r4_reg <= r_sel;
            g4_reg <= g_sel;
            b4_reg <= b_sel;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: scale each channel by 255 as (c << 8) - c and truncate.
    // This is the output register.
    // ------------------------------------------------------------------
    localparam int SCALE_W = UNIT_W + CHAN_W;

    logic [SCALE_W-1:0] r_scaled;
    logic [SCALE_W-1:0] g_scaled;
    logic [SCALE_W-1:0] b_scaled;

    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;

    assign r_scaled = (SCALE_W'(r4_reg) << CHAN_W) - SCALE_W'(r4_reg);
    assign g_scaled = (SCALE_W'(g4_reg) << CHAN_W) - SCALE_W'(g4_reg);
    assign b_scaled = (SCALE_W'(b4_reg) << CHAN_W) - SCALE_W'(b4_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            red_reg   <= r_scaled[FRAC_BITS +: CHAN_W];
            green_reg <= g_scaled[FRAC_BITS +: CHAN_W];
            blue_reg  <= b_scaled[FRAC_BITS +: CHAN_W];
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// File: hw/rtl/hslrgb_checker.sv
// Port-level assertions of the HSL to RGB converter and their binding to it.
`timescale 1ns / 1ps

module hslrgb_checker
    import hslrgb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              pix_valid,
    input logic              pix_stall,
    input logic              rgb_valid,
    input logic              rgb_stall,
    input logic [CHAN_W-1:0] red,
    input logic [CHAN_W-1:0] green,
    input logic [CHAN_W-1:0] blue
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> rgb_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> $stable(red) && $stable(green) && $stable(blue))
        else $error("result changed while stalled");

    // With no output stall and no reset in between, a transferred pixel reaches the output.
    assert property (@(posedge clk)
        $past(pix_valid && !pix_stall && rst_n, 6)
        && $past(!rgb_stall && rst_n, 1) && $past(!rgb_stall && rst_n, 2)
        && $past(!rgb_stall && rst_n, 3) && $past(!rgb_stall && rst_n, 4)
        && $past(!rgb_stall && rst_n, 5) && rst_n
        |-> rgb_valid)
        else $error("result missing after pipeline latency");

    // Reset empties the pipeline.
    assert property (@(posedge clk) !rst_n |=> !rgb_valid)
        else $error("result offered straight after reset");

endmodule

bind hsl_to_rgb_converter hslrgb_checker u_hslrgb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .red       (red),
    .green     (green),
    .blue      (blue)
);
